@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the queue RTL.
// Depends on nothing; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

@@ hw/rtl/depq_pkg.sv @@
// Package for the double-ended priority queue: codes, states and sizes.
// Depends on nothing.
`default_nettype none
package depq_pkg;
    localparam int DEFAULT_CAPACITY = 1024;
    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DEL_MAX = 2'd1,
        KIND_DEL_MIN = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_LAST,
        ST_MOVE,
        ST_SCAN,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

@@ hw/rtl/depq_scan.sv @@
// Scan unit: signed compares take one valid entry per cycle and keep the running max and min
// with their indexes over the entries streamed in. Uses depq_pkg.
`default_nettype none
module depq_scan
    import depq_pkg::*;
#(
    parameter int IDX_W = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_start,
    input  wire logic               i_valid,
    input  wire logic [IDX_W-1:0]   i_idx,
    input  wire logic [VALUE_W-1:0] i_data,
    output logic [VALUE_W-1:0]      o_max,
    output logic [VALUE_W-1:0]      o_min,
    output logic [IDX_W-1:0]        o_max_idx,
    output logic [IDX_W-1:0]        o_min_idx
);
    logic signed [VALUE_W-1:0] r_max, r_min;
    logic [IDX_W-1:0] r_max_idx, r_min_idx;

    // The first entry after a start seeds both extremes; later ones replace
    // only on a strict improvement so the lowest index wins on ties.
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            if (i_start || $signed(i_data) > r_max) begin
                r_max <= i_data;
                r_max_idx <= i_idx;
            end
            if (i_start || $signed(i_data) < r_min) begin
                r_min <= i_data;
                r_min_idx <= i_idx;
            end
        end
    end

    assign o_max = r_max;
    assign o_min = r_min;
    assign o_max_idx = r_max_idx;
    assign o_min_idx = r_min_idx;
endmodule
`default_nettype wire

@@ hw/rtl/double_ended_priority_queue.sv @@
// Top level of the double-ended priority queue: sequencer, entry memory,
// output register. Depends on depq_pkg, depq_scan and assert_macros.svh.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_ready  | i_kind, i_value
//  output  | out       | o_valid / i_ready  | o_max_value, o_min_value,
//          |           |                    | o_is_empty, o_rejected
//
// An insert or a clear raises o_valid after a rescan of the stored entries;
// a removal first reads the last entry and moves it, then rescans.
// The time is set by a linear scan over the stored entries through the single
// compare unit and the one-read memory port, so it grows with the entry count.
// A removal moves the last entry into the hole, then the store is rescanned.
// Reset clears the entry count and the handshake state; memory contents are
// left as they are and never read before being written.
// A pending result holds until taken; the next word is accepted at the
// earliest in the cycle after the result is taken.
`default_nettype none
`include "assert_macros.svh"
module double_ended_priority_queue
    import depq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [1:0]          i_kind,
    input  wire logic signed [31:0]  i_value,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [31:0]       o_max_value,
    output logic signed [31:0]       o_min_value,
    output logic                     o_is_empty,
    output logic                     o_rejected
);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] r_rd_data;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_hole, n_hole;
    logic r_rd_vld, n_rd_vld;
    logic r_first, n_first;
    logic r_rej, n_rej;
    logic r_out_vld, n_out_vld;
    logic [VALUE_W-1:0] r_max, r_min;
    logic r_empty;
    logic load_out;

    logic rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic [VALUE_W-1:0] s_max, s_min;
    logic [IDX_W-1:0] s_max_idx, s_min_idx;
    logic [IDX_W-1:0] r_scan_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        r_scan_idx <= rd_addr;
    end

    depq_scan #(.IDX_W(IDX_W)) u_scan (
        .i_clk     (i_clk),
        .i_start   (r_first),
        .i_valid   (r_rd_vld),
        .i_idx     (r_scan_idx),
        .i_data    (r_rd_data),
        .o_max     (s_max),
        .o_min     (s_min),
        .o_max_idx (s_max_idx),
        .o_min_idx (s_min_idx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_out_vld <= n_out_vld;
            r_rd_vld <= n_rd_vld;
            r_first <= n_first;
        end
        r_ptr <= n_ptr;
        r_hole <= n_hole;
        r_rej <= n_rej;
        if (load_out) begin
            r_empty <= (r_count == '0);
            r_max <= (r_count == '0) ? '0 : s_max;
            r_min <= (r_count == '0) ? '0 : s_min;
        end
    end

    assign o_ready = (r_state == ST_IDLE) && !r_out_vld;
    assign o_valid = r_out_vld;
    assign o_max_value = r_max;
    assign o_min_value = r_min;
    assign o_is_empty = r_empty;
    assign o_rejected = r_rej;

    // Scan: reads are issued for index 0..count-1; each read lands in the
    // compare unit in the following cycle. r_first marks the seed entry.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr = r_ptr;
        n_hole = r_hole;
        n_rej = r_rej;
        n_rd_vld = 1'b0;
        n_first = 1'b0;
        n_out_vld = r_out_vld && !i_ready;
        load_out = 1'b0;
        rd_en = 1'b0;
        rd_addr = r_ptr;
        wr_en = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_data = i_value;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid && o_ready) begin
                    n_rej = 1'b0;
                    n_ptr = '0;
                    n_state = ST_SCAN;
                    unique case (t_kind'(i_kind))
                        KIND_INSERT: begin
                            if (r_count >= CAP_C) begin
                                n_rej = 1'b1;
                            end else begin
                                wr_en = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        KIND_DEL_MAX, KIND_DEL_MIN: begin
                            if (r_count == '0) begin
                                n_rej = 1'b1;
                            end else begin
                                // Current extremes are in the scan unit from
                                // the previous word's rescan.
                                n_hole = (t_kind'(i_kind) == KIND_DEL_MAX)
                                    ? s_max_idx : s_min_idx;
                                n_state = ST_READ_LAST;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ_LAST: begin
                rd_en = 1'b1;
                rd_addr = IDX_W'(r_count - 1'b1);
                n_count = r_count - 1'b1;
                n_state = ST_MOVE;
            end
            ST_MOVE: begin
                wr_en = 1'b1;
                wr_addr = r_hole;
                wr_data = r_rd_data;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if ({1'b0, r_ptr} < r_count) begin
                    rd_en = 1'b1;
                    n_rd_vld = 1'b1;
                    n_first = (r_ptr == '0);
                    n_ptr = r_ptr + 1'b1;
                    if ({1'b0, r_ptr} == r_count - 1'b1) begin
                        n_state = ST_OUT;
                    end
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // Wait while r_rd_vld is high, until the last read has landed in the unit.
                if (!r_rd_vld) begin
                    load_out = 1'b1;
                    n_out_vld = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    logic out_stall;
    logic out_empty;
    assign out_stall = o_valid && !i_ready;
    assign out_empty = o_valid && o_is_empty;

    `ASSERT_IMPLIES(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CAP_C)
    `ASSERT_IMPLIES(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == ST_IDLE)
    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, out_stall, o_valid && $stable(o_max_value))
    `ASSERT_IMPLIES(a_empty_zero, i_clk, i_rst_n, out_empty, o_max_value == 0 && o_min_value == 0)
endmodule
`default_nettype wire
